FILE: sv/tcnw_pkg.sv
// shared types, constants and helpers for the text console number writer
// no dependencies; used by every module of the block except tcnw_ram
`timescale 1ns / 1ps
`default_nettype none

package tcnw_pkg;

  localparam int COLUMNS  = 96;
  localparam int ROWS     = 40;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int CURSOR_W = $clog2(CELLS + 1);
  localparam int NL_W     = CURSOR_W + 1;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int CIDX_W   = 12;

  // longest output run: minus sign plus ten decimal digits
  localparam int MAXCH    = 11;
  localparam int CNT_W    = $clog2(MAXCH + 1);
  localparam int BUF_AW   = $clog2(MAXCH);

  localparam int IN_W     = 48;
  localparam int OP_W     = 3;
  localparam int OUT_W    = 24;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_A     = 8'h61;

  typedef enum logic [OP_W-1:0] {
    OP_PUTC   = 3'd0,
    OP_UDEC   = 3'd1,
    OP_SDEC   = 3'd2,
    OP_HEX    = 3'd3,
    OP_SETCUR = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_RDWAIT,
    ST_RDOUT
  } st_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
    logic rd_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clear_last;
    logic conv_last;
    logic last_char;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] g);
    logic [7:0] c;
    if (g < 4'd10) begin
      c = CH_ZERO + 8'(g);
    end else begin
      c = CH_A + 8'(g) - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tcnw_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcnw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/tcnw_ctrl.sv
// controller state machine: clearing pass, item accept, conversion, emission, cell read-out
// depends on tcnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcnw_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  tcnw_pkg::stat_t status,
  output tcnw_pkg::cmd_t  cmd
);

  tcnw_pkg::st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcnw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      tcnw_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = tcnw_pkg::ST_IDLE;
        end
      end
      tcnw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (status.op)
            tcnw_pkg::OP_PUTC, tcnw_pkg::OP_HEX: state_next = tcnw_pkg::ST_EMIT;
            tcnw_pkg::OP_UDEC, tcnw_pkg::OP_SDEC: state_next = tcnw_pkg::ST_CONV;
            tcnw_pkg::OP_READ: state_next = tcnw_pkg::ST_RDWAIT;
            default: state_next = tcnw_pkg::ST_IDLE;
          endcase
        end
      end
      tcnw_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_next = tcnw_pkg::ST_EMIT;
        end
      end
      tcnw_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_char) begin
            state_next = tcnw_pkg::ST_IDLE;
          end
        end
      end
      tcnw_pkg::ST_RDWAIT: begin
        state_next = tcnw_pkg::ST_RDOUT;
      end
      tcnw_pkg::ST_RDOUT: begin
        if (status.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = tcnw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcnw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/tcnw_dp.sv
// datapath: cursor and column, digit conversion, character buffer,
// framebuffer ram and output register; depends on tcnw_pkg and tcnw_ram
`timescale 1ns / 1ps
`default_nettype none

module tcnw_dp (
  input  wire                           clk,
  input  wire                           rst,
  input  tcnw_pkg::cmd_t                cmd,
  output tcnw_pkg::stat_t               status,
  input  wire  [tcnw_pkg::OP_W-1:0]     in_op,
  input  wire  [tcnw_pkg::IN_W-1:0]     in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [tcnw_pkg::OUT_W-1:0]    out_data,
  output logic                          out_last
);

  logic [tcnw_pkg::CURSOR_W-1:0] cursor;
  logic [tcnw_pkg::COL_W-1:0]    col;
  logic [tcnw_pkg::CELL_AW-1:0]  clr_addr;
  logic [tcnw_pkg::CELL_AW-1:0]  rd_addr;
  logic                          rd_ok;
  logic [31:0]                   num;
  logic                          neg;
  logic [7:0]                    chars [tcnw_pkg::MAXCH];
  logic [tcnw_pkg::CNT_W-1:0]    cnt;

  logic [31:0] in_value;
  logic [7:0]  in_x;
  logic [7:0]  in_y;
  tcnw_pkg::op_t op;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;

  logic [7:0]  ch;
  logic        is_nl;
  logic        full;
  logic        store;
  logic [tcnw_pkg::NL_W-1:0] nl_sum;
  logic [tcnw_pkg::CURSOR_W-1:0] nl_cursor;

  logic [8:0]  xc;
  logic [7:0]  yc;

  logic [tcnw_pkg::CNT_W-1:0] hex_cnt;

  logic [7:0]  ram_rdata;
  logic        ram_we;
  logic [tcnw_pkg::CELL_AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;

  assign in_value = in_data[31:0];
  assign in_x     = in_data[39:32];
  assign in_y     = in_data[47:40];
  assign op       = tcnw_pkg::op_t'(in_op);

  // divide by ten through the reciprocal
  assign prod = 64'(num) * 64'h0000_0000_cccc_cccd;
  assign quot = 32'(prod[63:35]);
  assign rem  = 4'(num - ((quot << 3) + (quot << 1)));

  assign ch     = chars[tcnw_pkg::BUF_AW'(cnt - tcnw_pkg::CNT_W'(1))];
  assign is_nl  = (ch == tcnw_pkg::CH_NL);
  assign full   = (cursor >= tcnw_pkg::CURSOR_W'(tcnw_pkg::CELLS));
  assign store  = cmd.emit && !is_nl && !full;
  assign nl_sum = tcnw_pkg::NL_W'(cursor) + tcnw_pkg::NL_W'(tcnw_pkg::COLUMNS)
                  - tcnw_pkg::NL_W'(col);
  assign nl_cursor = (nl_sum > tcnw_pkg::NL_W'(tcnw_pkg::CELLS))
                     ? tcnw_pkg::CURSOR_W'(tcnw_pkg::CELLS)
                     : tcnw_pkg::CURSOR_W'(nl_sum);

  // clamp the requested position; the row past the last one (y = ROWS) only has column 0
  always_comb begin
    xc = (9'(in_x) > 9'(tcnw_pkg::COLUMNS)) ? 9'(tcnw_pkg::COLUMNS) : 9'(in_x);
    yc = (in_y > 8'(tcnw_pkg::ROWS)) ? 8'(tcnw_pkg::ROWS) : in_y;
    if (yc == 8'(tcnw_pkg::ROWS)) begin
      xc = '0;
    end
  end

  // significant hex digits, at least one
  always_comb begin
    hex_cnt = tcnw_pkg::CNT_W'(1);
    for (int i = 0; i < 8; i++) begin
      if (in_value[4*i +: 4] != 4'd0) begin
        hex_cnt = tcnw_pkg::CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (op)
        tcnw_pkg::OP_PUTC: begin
          chars[0] <= in_value[7:0];
        end
        tcnw_pkg::OP_HEX: begin
          for (int i = 0; i < 8; i++) begin
            chars[i] <= tcnw_pkg::hex_char(in_value[4*i +: 4]);
          end
        end
        tcnw_pkg::OP_UDEC: begin
          num <= in_value;
          neg <= 1'b0;
        end
        tcnw_pkg::OP_SDEC: begin
          num <= in_value[31] ? (32'd0 - in_value) : in_value;
          neg <= in_value[31];
        end
        tcnw_pkg::OP_READ: begin
          rd_addr <= tcnw_pkg::CELL_AW'(in_value);
          rd_ok   <= (in_value < 32'(tcnw_pkg::CELLS));
        end
        default: begin
        end
      endcase
    end else if (cmd.conv) begin
      chars[tcnw_pkg::BUF_AW'(cnt)] <= tcnw_pkg::CH_ZERO + 8'(rem);
      num <= quot;
      if (quot == 32'd0 && neg) begin
        chars[tcnw_pkg::BUF_AW'(cnt + tcnw_pkg::CNT_W'(1))] <= tcnw_pkg::CH_MINUS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      col       <= '0;
      clr_addr  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + tcnw_pkg::CELL_AW'(1);
      end

      if (cmd.load) begin
        case (op)
          tcnw_pkg::OP_PUTC: cnt <= tcnw_pkg::CNT_W'(1);
          tcnw_pkg::OP_HEX:  cnt <= hex_cnt;
          tcnw_pkg::OP_UDEC, tcnw_pkg::OP_SDEC: cnt <= '0;
          tcnw_pkg::OP_SETCUR: begin
            cursor <= tcnw_pkg::CURSOR_W'(32'(yc) * tcnw_pkg::COLUMNS + 32'(xc));
            col    <= (xc == 9'(tcnw_pkg::COLUMNS)) ? '0 : tcnw_pkg::COL_W'(xc);
          end
          default: begin
          end
        endcase
      end else if (cmd.conv) begin
        cnt <= cnt + ((quot == 32'd0 && neg) ? tcnw_pkg::CNT_W'(2) : tcnw_pkg::CNT_W'(1));
      end else if (cmd.emit) begin
        cnt <= cnt - tcnw_pkg::CNT_W'(1);
        if (is_nl) begin
          if (col != '0) begin
            cursor <= nl_cursor;
            col    <= '0;
          end
        end else if (!full) begin
          cursor <= cursor + tcnw_pkg::CURSOR_W'(1);
          col    <= (col == tcnw_pkg::COL_W'(tcnw_pkg::COLUMNS - 1))
                    ? '0 : col + tcnw_pkg::COL_W'(1);
        end
      end

      if (cmd.emit || cmd.rd_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word: character, cell index, stored, accepted
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {2'b00, is_nl || !full, store,
                   tcnw_pkg::CIDX_W'(cursor), ch};
      out_last <= (cnt == tcnw_pkg::CNT_W'(1));
    end else if (cmd.rd_out) begin
      if (rd_ok) begin
        out_data <= {2'b00, 1'b1, 1'b0, tcnw_pkg::CIDX_W'(rd_addr), ram_rdata};
      end else begin
        out_data <= {2'b00, 1'b0, 1'b0, tcnw_pkg::CIDX_W'(tcnw_pkg::CELLS), 8'd0};
      end
      out_last <= 1'b1;
    end
  end

  assign ram_we    = cmd.clear || store;
  assign ram_waddr = cmd.clear ? clr_addr : tcnw_pkg::CELL_AW'(cursor);
  assign ram_wdata = cmd.clear ? 8'd0 : ch;

  tcnw_ram #(
    .WIDTH (8),
    .DEPTH (tcnw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign status.op         = op;
  assign status.clear_last = (clr_addr == tcnw_pkg::CELL_AW'(tcnw_pkg::CELLS - 1));
  assign status.conv_last  = (quot == 32'd0);
  assign status.last_char  = (cnt == tcnw_pkg::CNT_W'(1));
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: sv/text_console_number_writer_top.sv
// top level of the text console number writer: controller plus datapath
// depends on tcnw_pkg, tcnw_ctrl, tcnw_dp and tcnw_ram
`timescale 1ns / 1ps
`default_nettype none

// Writes characters and numbers into a 96x40 byte screen and reports every
// character put out, one result word each. After reset the screen memory is
// cleared one cell a cycle, while no word is taken in. One item is handled at
// a time: put char is accepted and then emitted, hex emits one character per
// digit after the accept, decimal takes a divide-by-ten step per digit, then
// one emission per digit plus one for a minus sign, set cursor is only
// accepted, and read cell waits on the registered read of the screen memory
// before its word goes out. A busy output side stalls the emission and read-out
// steps only; the output register lets the next word in while the result waits.
module text_console_number_writer_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // value[31:0], pos_x[39:32], pos_y[47:40]
  input  wire  [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // character[7:0], cell_index[19:8],
                                      // stored[20], accepted[21], zero[23:22]
  output logic        m_axis_tlast
);

  tcnw_pkg::cmd_t  cmd;
  tcnw_pkg::stat_t status;

  tcnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcnw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // a result is only produced into a free output register
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.rd_out) |-> status.out_free)
    else $error("result word overwritten while waiting");

  // controller issues at most one command a cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.conv, cmd.emit, cmd.rd_out, cmd.clear}))
    else $error("conflicting datapath commands");

  // a stored character is always an accepted one
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[20]) |-> m_axis_tdata[21])
    else $error("stored without accepted");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_text_console_number_writer_top.sv
// self-checking testbench for the text console number writer
// depends on tcnw_pkg and text_console_number_writer_top; the screen, cursor and
// column are modelled here and every output word is checked against that model
`timescale 1ns / 1ps

module tb_text_console_number_writer_top;
  import tcnw_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 395;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic [7:0]  x;
    logic [7:0]  y;
  } console_cmd_t;

  typedef struct {
    logic [7:0]  character;
    logic [11:0] cell_index;
    logic        stored;
    logic        accepted;
    logic        last;
  } console_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  text_console_number_writer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // screen model
  logic [7:0]    screen_model [CELLS];
  logic [11:0]   cursor_model = '0;
  logic [6:0]    column_model = '0;
  console_word_t item_words[$];
  console_word_t expected_words[$];
  console_cmd_t  pending_cmds[$];
  int            mismatches = 0;
  int            cycle_count = 0;

  initial begin
    foreach (screen_model[i]) screen_model[i] = 8'h00;
  end

  task automatic emit_word(input logic [7:0] ch, input logic [11:0] idx, input logic st,
                           input logic acc);
    console_word_t w;
    w.character = ch;
    w.cell_index = idx;
    w.stored = st;
    w.accepted = acc;
    w.last = 1'b0;
    item_words.push_back(w);
  endtask

  task automatic put_screen_char(input logic [7:0] ch);
    logic [11:0] at;
    int next_pos;
    at = cursor_model;
    if (ch == CH_NL) begin
      // newline only moves when the column is nonzero
      if (column_model != 0) begin
        next_pos = int'(cursor_model) + COLUMNS - int'(column_model);
        cursor_model = (next_pos > CELLS) ? 12'(CELLS) : 12'(next_pos);
        column_model = '0;
      end
      emit_word(ch, at, 1'b0, 1'b1);
    end else if (cursor_model >= CELLS) begin
      emit_word(ch, at, 1'b0, 1'b0);
    end else begin
      screen_model[cursor_model] = ch;
      cursor_model = cursor_model + 12'd1;
      column_model = column_model + 7'd1;
      if (column_model >= COLUMNS) column_model = '0;
      emit_word(ch, at, 1'b1, 1'b1);
    end
  endtask

  task automatic print_decimal(input logic [31:0] num);
    logic [7:0]  digits [10];
    logic [31:0] rest;
    int k;
    rest = num;
    k = 0;
    if (rest == 0) begin
      put_screen_char(CH_ZERO);
    end else begin
      while (rest != 0) begin
        digits[k] = CH_ZERO + 8'(rest % 32'd10);
        rest = rest / 32'd10;
        k++;
      end
      while (k > 0) begin
        k--;
        put_screen_char(digits[k]);
      end
    end
  endtask

  task automatic print_hex(input logic [31:0] num);
    logic [7:0]  digits [8];
    logic [31:0] rest;
    logic [3:0]  nib;
    int k;
    rest = num;
    k = 0;
    if (rest == 0) begin
      put_screen_char(CH_ZERO);
    end else begin
      while (rest != 0) begin
        nib = rest[3:0];
        digits[k] = (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10;
        rest = rest >> 4;
        k++;
      end
      while (k > 0) begin
        k--;
        put_screen_char(digits[k]);
      end
    end
  endtask

  task automatic predict_console(input console_cmd_t cmd);
    console_word_t w;
    int cx;
    int cy;
    item_words.delete();
    case (cmd.op)
      OP_PUTC: put_screen_char(cmd.value[7:0]);
      OP_UDEC: print_decimal(cmd.value);
      OP_SDEC: begin
        if (cmd.value[31]) begin
          put_screen_char(CH_MINUS);
          print_decimal(32'd0 - cmd.value);
        end else begin
          print_decimal(cmd.value);
        end
      end
      OP_HEX: print_hex(cmd.value);
      OP_SETCUR: begin
        cx = (cmd.x > COLUMNS) ? COLUMNS : int'(cmd.x);
        cy = (cmd.y > ROWS) ? ROWS : int'(cmd.y);
        if (cy == ROWS) cx = 0;
        cursor_model = 12'(cy * COLUMNS + cx);
        column_model = (cx == COLUMNS) ? 7'd0 : 7'(cx);
      end
      OP_READ: begin
        if (cmd.value < CELLS) begin
          emit_word(screen_model[cmd.value[11:0]], cmd.value[11:0], 1'b0, 1'b1);
        end else begin
          emit_word(8'h00, 12'(CELLS), 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
    if (item_words.size() > 0) begin
      w = item_words.pop_back();
      w.last = 1'b1;
      item_words.push_back(w);
    end
    foreach (item_words[i]) expected_words.push_back(item_words[i]);
  endtask

  // sender: bursts of words with random gaps
  console_cmd_t drive_cmd;
  logic         drive_have;
  int           gap_left = 0;
  int           burst_left = 0;
  int           gap_pick;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      drive_have = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_console(drive_cmd);
        drive_have = 1'b0;
      end
      if (!drive_have) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          drive_cmd = pending_cmds.pop_front();
          drive_have = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0) begin
            gap_pick = $urandom_range(0, 9);
            if (gap_pick < 4) gap_left = 0;
            else if (gap_pick < 8) gap_left = $urandom_range(1, 4);
            else gap_left = $urandom_range(5, 30);
          end
        end
      end
      s_axis_tvalid <= drive_have;
      s_axis_tdata <= {drive_cmd.y, drive_cmd.x, drive_cmd.value};
      s_axis_tuser <= drive_cmd.op;
    end
  end

  // receiver: stall pattern chosen by bits 9:8 of the cycle count
  int   stall_left = 0;
  logic ready_next;

  task automatic check_word();
    console_word_t want;
    if (expected_words.size() == 0) begin
      if (mismatches < 50) begin
        $display("%0t: unexpected word, got char %h index %0d stored %b accepted %b last %b",
                 $time, m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[20],
                 m_axis_tdata[21], m_axis_tlast);
      end
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      if (m_axis_tdata[7:0] !== want.character || m_axis_tdata[19:8] !== want.cell_index ||
          m_axis_tdata[20] !== want.stored || m_axis_tdata[21] !== want.accepted ||
          m_axis_tdata[23:22] !== 2'b00 || m_axis_tlast !== want.last) begin
        if (mismatches < 50) begin
          $display("%0t: expected %h %0d %b %b %b 00, got %h %0d %b %b %b %b (char idx st acc last pad)",
                   $time, want.character, want.cell_index, want.stored, want.accepted,
                   want.last, m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[20],
                   m_axis_tdata[21], m_axis_tlast, m_axis_tdata[23:22]);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        case (cycle_count[9:8])
          2'd0: ready_next = 1'b1;
          2'd1: ready_next = ($urandom_range(0, 3) != 0);
          2'd2: ready_next = ((cycle_count % 5) < 2);
          default: begin
            ready_next = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 20);
          end
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_console_number_writer_top NOT OK");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [31:0] value, input logic [7:0] x,
                           input logic [7:0] y);
    console_cmd_t c;
    c.op = op;
    c.value = value;
    c.x = x;
    c.y = y;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_words.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int          random_items;
    int          pick;
    int          base_index;
    int          cx;
    int          cy;
    logic [31:0] mag;
    logic [7:0]  ch;
    logic [2:0]  num_op;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic        paused;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    queue_cmd(OP_PUTC, 32'hffffff00, 8'h00, 8'h00);
    queue_cmd(OP_PUTC, 32'h000000ff, 8'hff, 8'hff);
    queue_cmd(OP_PUTC, 32'(CH_NL), 8'h00, 8'h00);     // column nonzero: jumps a row
    queue_cmd(OP_PUTC, 32'(CH_NL), 8'h00, 8'h00);     // column zero: stays put
    queue_cmd(OP_UDEC, 32'h00000000, 8'h00, 8'h00);
    queue_cmd(OP_UDEC, 32'hffffffff, 8'h00, 8'h00);
    queue_cmd(OP_SDEC, 32'h80000000, 8'h00, 8'h00);
    queue_cmd(OP_SDEC, 32'hffffffff, 8'h00, 8'h00);
    queue_cmd(OP_SDEC, 32'h7fffffff, 8'h00, 8'h00);
    queue_cmd(OP_HEX, 32'h00000000, 8'h00, 8'h00);
    queue_cmd(OP_HEX, 32'hffffffff, 8'h00, 8'h00);
    queue_cmd(OP_HEX, 32'hfedcba98, 8'h00, 8'h00);
    queue_cmd(OP_SETCUR, 32'h0, 8'hff, 8'hff);        // both clamped, row y = ROWS forces x 0
    queue_cmd(OP_PUTC, 32'h58, 8'h00, 8'h00);
    queue_cmd(OP_READ, 32'd0, 8'h00, 8'h00);
    queue_cmd(OP_READ, 32'd1, 8'h00, 8'h00);
    queue_cmd(OP_SETCUR, 32'h0, 8'd96, 8'd5);         // column 96 reads back as 0
    queue_cmd(OP_SETCUR, 32'h0, 8'd95, 8'd39);
    queue_cmd(OP_PUTC, 32'h41, 8'h00, 8'h00);         // last cell, then screen is full
    queue_cmd(OP_PUTC, 32'h42, 8'h00, 8'h00);
    queue_cmd(OP_PUTC, 32'(CH_NL), 8'h00, 8'h00);
    queue_cmd(OP_UDEC, 32'd7, 8'h00, 8'h00);
    queue_cmd(OP_READ, 32'd3839, 8'h00, 8'h00);
    queue_cmd(OP_READ, 32'd3840, 8'h00, 8'h00);
    queue_cmd(OP_READ, 32'hffffffff, 8'h00, 8'h00);
    queue_cmd(OP_SPARE6, 32'hffffffff, 8'hff, 8'hff);
    queue_cmd(OP_SPARE7, 32'h12345678, 8'h00, 8'h00);
    queue_cmd(OP_SETCUR, 32'h0, 8'd50, 8'd39);
    queue_cmd(OP_PUTC, 32'(CH_NL), 8'h00, 8'h00);     // newline lands exactly on the end
    wait_drained();

    // random part
    queue_cmd(OP_SETCUR, 32'h0, 8'h00, 8'h00);
    base_index = 0;
    random_items = 0;
    paused = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      if (!paused && random_items >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 3))
          0: ch = CH_NL;
          1: ch = 8'($urandom_range(0, 255));
          default: ch = 8'($urandom_range(32, 126));
        endcase
        queue_cmd(OP_PUTC, {$urandom()} & 32'hffffff00 | 32'(ch), 8'($urandom()),
                  8'($urandom()));
        random_items++;
      end else if (pick < 65) begin
        num_op = 3'($urandom_range(int'(OP_UDEC), int'(OP_HEX)));
        mag = $urandom() >> $urandom_range(0, 31);
        if (num_op == OP_SDEC && $urandom_range(0, 1) == 1) mag = 32'd0 - mag;
        queue_cmd(num_op, mag, 8'($urandom()), 8'($urandom()));
        random_items++;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) == 1) begin
          rx = 8'($urandom());
          ry = 8'($urandom());
        end else begin
          rx = 8'($urandom_range(0, 96));
          ry = 8'($urandom_range(0, 39));
        end
        cx = (rx > COLUMNS) ? COLUMNS : int'(rx);
        cy = (ry > ROWS) ? ROWS : int'(ry);
        if (cy == ROWS) cx = 0;
        base_index = cy * COLUMNS + cx;
        queue_cmd(OP_SETCUR, $urandom(), rx, ry);
        random_items++;
      end else if (pick < 82) begin
        // run off the end of the screen, then come back near the top
        queue_cmd(OP_SETCUR, $urandom(), 8'($urandom_range(84, 96)), 8'd39);
        queue_cmd(OP_SDEC, $urandom(), 8'h00, 8'h00);
        queue_cmd(OP_PUTC, 32'($urandom_range(32, 126)), 8'h00, 8'h00);
        queue_cmd(OP_PUTC, 32'(CH_NL), 8'h00, 8'h00);
        queue_cmd(OP_READ, 32'($urandom_range(3830, 3845)), 8'h00, 8'h00);
        rx = 8'($urandom_range(0, 95));
        ry = 8'($urandom_range(0, 20));
        base_index = int'(ry) * COLUMNS + int'(rx);
        queue_cmd(OP_SETCUR, 32'h0, rx, ry);
        random_items += 6;
      end else if (pick < 96) begin
        case ($urandom_range(0, 9))
          0, 1: mag = $urandom();
          2: mag = 32'($urandom_range(3835, 3845));
          3: mag = 32'($urandom_range(0, CELLS - 1));
          default: mag = 32'(base_index + $urandom_range(0, 24));
        endcase
        queue_cmd(OP_READ, mag, 8'($urandom()), 8'($urandom()));
        random_items++;
      end else begin
        queue_cmd(($urandom_range(0, 1) == 1) ? OP_SPARE7 : OP_SPARE6, $urandom(),
                  8'($urandom()), 8'($urandom()));
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_text_console_number_writer_top OK");
    end else begin
      if (expected_words.size() > 0) begin
        $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      end
      $display("tb_text_console_number_writer_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tcnw_pkg.sv
sv/tcnw_ram.sv
sv/tcnw_ctrl.sv
sv/tcnw_dp.sv
sv/text_console_number_writer_top.sv
tb/tb_text_console_number_writer_top.sv
